[src/cll_pkg.sv]
package cll_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE,
    S_STEP,
    S_ALLOC,
    S_LINK,
    S_DEL,
    S_FETCH,
    S_DONE
  } state_t;

  localparam logic [3:0] CMD_MOVE_NEXT  = 4'd0;
  localparam logic [3:0] CMD_MOVE_PREV  = 4'd1;
  localparam logic [3:0] CMD_MOVE_FIRST = 4'd2;
  localparam logic [3:0] CMD_MOVE_LAST  = 4'd3;
  localparam logic [3:0] CMD_ADD_NEXT   = 4'd4;
  localparam logic [3:0] CMD_ADD_PREV   = 4'd5;
  localparam logic [3:0] CMD_ADD_FIRST  = 4'd6;
  localparam logic [3:0] CMD_ADD_LAST   = 4'd7;
  localparam logic [3:0] CMD_DEL_CUR    = 4'd8;
  localparam logic [3:0] CMD_DEL_NEXT   = 4'd9;
  localparam logic [3:0] CMD_DEL_PREV   = 4'd10;
  localparam logic [3:0] CMD_DEL_FIRST  = 4'd11;
  localparam logic [3:0] CMD_DEL_LAST   = 4'd12;

endpackage

[src/cll_ram.sv]
module cll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/cursor_linked_list_engine_unit.sv]
// Doubly linked list with a cursor over a pool of POOL_DEPTH nodes. A command
// (command, value) is taken when start is high and busy is low; its result
// appears on the result ports for exactly one cycle with done high, and the
// receiver must take it then. Busy stays high until a command is through, so
// the next is taken only after it. Commands turned away at issue (empty list,
// unused code) and moves to first/last go from issue straight to fetch. Moves
// next/prev, delete at cursor/first/last, delete next/prev with no neighbour,
// an add into an empty list and an add refused by a full pool also pass a
// step, delete or allocate state. Other adds pass allocate and link; delete
// next/prev pass step and delete. Node memory reads are registered: each link
// read must return before the dependent writes and the final read of the data
// under the cursor. The memories need no clearing after reset.
module cursor_linked_list_engine_unit #(
  parameter int POOL_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [3:0]                             command,
  input  logic signed [DATA_WIDTH-1:0]           value,
  output logic                                   done,
  output logic                                   ok,
  output logic                                   took_value,
  output logic signed [DATA_WIDTH-1:0]           removed_value,
  output logic signed [DATA_WIDTH-1:0]           cursor_value,
  output logic [$clog2(POOL_DEPTH+1)-1:0]        node_count,
  output logic                                   pool_full
);

  import cll_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  state_t state, state_next;
  logic [3:0]            cmd, cmd_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic [LW-1:0]         head, head_next, tail, tail_next, cursor, cursor_next;
  logic [LW-1:0]         free_top, free_top_next, fresh, fresh_next;
  logic [LW-1:0]         node, node_next, cnode, cnode_next, tlink, tlink_next;
  logic [LW-1:0]         count_next;
  logic                  ok_next, took_next, full_next;
  logic [DATA_WIDTH-1:0] removed_next;

  // memory ports
  logic                  d_we, d_re, nl_we, nl_re, pl_we, pl_re, fs_we, fs_re;
  logic [AW-1:0]         d_waddr, d_raddr, nl_waddr, pl_waddr, l_raddr;
  logic [AW-1:0]         fs_waddr, fs_raddr;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic [LW-1:0]         nl_wdata, pl_wdata, nl_rdata, pl_rdata;
  logic [AW-1:0]         fs_wdata, fs_rdata;

  logic [LW-1:0] top_m1, t, n_pick, nx, pv, cur_del;
  logic          after, fwd, is_move;

  function automatic logic live(input logic [LW-1:0] i);
    return i < NIL;
  endfunction

  cll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );
  cll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .re(nl_re), .raddr(l_raddr), .rdata(nl_rdata)
  );
  cll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .re(pl_re), .raddr(l_raddr), .rdata(pl_rdata)
  );
  cll_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .re(fs_re), .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign cursor_value = live(cursor) ? d_rdata : '0;
  assign top_m1 = free_top - LW'(1);
  assign after = (cmd == CMD_ADD_NEXT) || (cmd == CMD_ADD_LAST);
  assign fwd = (cmd == CMD_MOVE_NEXT) || (cmd == CMD_DEL_NEXT);
  assign is_move = (cmd == CMD_MOVE_NEXT) || (cmd == CMD_MOVE_PREV);
  assign t = (after || fwd) ? nl_rdata : pl_rdata;
  assign n_pick = (free_top != '0) ? {{(LW-AW){1'b0}}, fs_rdata} : fresh;
  assign nx = nl_rdata;
  assign pv = pl_rdata;
  // removing the tail of a longer list leaves the cursor on the new tail
  assign cur_del = (node == tail && node != head) ? pv : nx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= NIL;
      tail          <= NIL;
      cursor        <= NIL;
      node_count    <= '0;
      free_top      <= '0;
      fresh         <= '0;
      ok            <= 1'b0;
      took_value    <= 1'b0;
      pool_full     <= 1'b0;
      removed_value <= '0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      cursor        <= cursor_next;
      node_count    <= count_next;
      free_top      <= free_top_next;
      fresh         <= fresh_next;
      ok            <= ok_next;
      took_value    <= took_next;
      pool_full     <= full_next;
      removed_value <= removed_next;
    end
    cmd   <= cmd_next;
    val   <= val_next;
    node  <= node_next;
    cnode <= cnode_next;
    tlink <= tlink_next;
  end

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    val_next      = val;
    head_next     = head;
    tail_next     = tail;
    cursor_next   = cursor;
    count_next    = node_count;
    free_top_next = free_top;
    fresh_next    = fresh;
    node_next     = node;
    cnode_next    = cnode;
    tlink_next    = tlink;
    ok_next       = ok;
    took_next     = took_value;
    full_next     = pool_full;
    removed_next  = removed_value;
    d_we = 1'b0; d_re = 1'b0; nl_we = 1'b0; nl_re = 1'b0;
    pl_we = 1'b0; pl_re = 1'b0; fs_we = 1'b0; fs_re = 1'b0;
    d_waddr = '0; d_raddr = '0; nl_waddr = '0; pl_waddr = '0; l_raddr = '0;
    fs_waddr = '0; fs_raddr = '0;
    d_wdata = val; nl_wdata = NIL; pl_wdata = NIL; fs_wdata = node[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next     = command;
          val_next     = value;
          ok_next      = 1'b0;
          took_next    = 1'b0;
          full_next    = 1'b0;
          removed_next = '0;
          state_next   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_next = S_FETCH;
        case (cmd)
          CMD_MOVE_NEXT, CMD_MOVE_PREV, CMD_DEL_NEXT, CMD_DEL_PREV: begin
            if (live(head)) begin
              nl_re = 1'b1; pl_re = 1'b1;
              l_raddr = cursor[AW-1:0];
              state_next = S_STEP;
            end
          end
          CMD_MOVE_FIRST: begin
            if (live(head)) begin
              cursor_next = head; ok_next = 1'b1;
            end
          end
          CMD_MOVE_LAST: begin
            if (live(tail)) begin
              cursor_next = tail; ok_next = 1'b1;
            end
          end
          CMD_ADD_NEXT, CMD_ADD_PREV, CMD_ADD_FIRST, CMD_ADD_LAST: begin
            if (live(head) || cmd == CMD_ADD_NEXT || cmd == CMD_ADD_PREV) begin
              if (cmd == CMD_ADD_FIRST) begin
                cursor_next = head; cnode_next = head;
              end else if (cmd == CMD_ADD_LAST) begin
                cursor_next = tail; cnode_next = tail;
              end else begin
                cnode_next = cursor;
              end
              nl_re = 1'b1; pl_re = 1'b1;
              l_raddr = cursor_next[AW-1:0];
              fs_re = (free_top != '0);
              fs_raddr = top_m1[AW-1:0];
              state_next = S_ALLOC;
            end
          end
          CMD_DEL_CUR, CMD_DEL_FIRST, CMD_DEL_LAST: begin
            if (live(head)) begin
              if (cmd == CMD_DEL_FIRST) node_next = head;
              else if (cmd == CMD_DEL_LAST) node_next = tail;
              else node_next = cursor;
              nl_re = 1'b1; pl_re = 1'b1; d_re = 1'b1;
              l_raddr = node_next[AW-1:0];
              d_raddr = node_next[AW-1:0];
              state_next = S_DEL;
            end
          end
          default: ;
        endcase
      end
      S_STEP: begin
        state_next = S_FETCH;
        if (live(t)) begin
          cursor_next = t;
          if (is_move) begin
            ok_next = 1'b1;
          end else begin
            node_next = t;
            nl_re = 1'b1; pl_re = 1'b1; d_re = 1'b1;
            l_raddr = t[AW-1:0];
            d_raddr = t[AW-1:0];
            state_next = S_DEL;
          end
        end
      end
      S_ALLOC: begin
        state_next = S_FETCH;
        tlink_next = t;
        if (free_top == '0 && fresh == NIL) begin
          full_next = 1'b1;
        end else begin
          if (free_top != '0) free_top_next = top_m1;
          else fresh_next = fresh + LW'(1);
          node_next = n_pick;
          d_we = 1'b1; d_waddr = n_pick[AW-1:0];
          nl_we = 1'b1; nl_waddr = n_pick[AW-1:0];
          pl_we = 1'b1; pl_waddr = n_pick[AW-1:0];
          ok_next = 1'b1;
          cursor_next = n_pick;
          if (!live(head)) begin
            head_next = n_pick; tail_next = n_pick;
            count_next = LW'(1);
          end else begin
            nl_wdata = after ? t : cnode;
            pl_wdata = after ? cnode : t;
            count_next = node_count + LW'(1);
            if (!live(t)) begin
              if (after) tail_next = n_pick;
              else head_next = n_pick;
            end
            state_next = S_LINK;
          end
        end
      end
      S_LINK: begin
        state_next = S_FETCH;
        nl_wdata = node;
        pl_wdata = node;
        if (after) begin
          nl_we = 1'b1; nl_waddr = cnode[AW-1:0];
          pl_we = live(tlink); pl_waddr = tlink[AW-1:0];
        end else begin
          pl_we = 1'b1; pl_waddr = cnode[AW-1:0];
          nl_we = live(tlink); nl_waddr = tlink[AW-1:0];
        end
      end
      S_DEL: begin
        state_next   = S_FETCH;
        took_next    = 1'b1;
        removed_next = d_rdata;
        nl_we = live(pv); nl_waddr = pv[AW-1:0]; nl_wdata = nx;
        pl_we = live(nx); pl_waddr = nx[AW-1:0]; pl_wdata = pv;
        if (free_top < NIL) begin
          fs_we = 1'b1; fs_waddr = free_top[AW-1:0];
          free_top_next = free_top + LW'(1);
        end
        if (node == head) head_next = nx;
        if (node == tail) tail_next = pv;
        cursor_next = cur_del;
        count_next = node_count - LW'(1);
        ok_next = live(cur_del);
      end
      S_FETCH: begin
        d_re = 1'b1;
        d_raddr = cursor[AW-1:0];
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    live(head) == live(tail))
    else $error("head and tail disagree on list emptiness");
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (node_count == '0) == !live(head))
    else $error("node count out of step with list");
  a_cursor_live: assert property (@(posedge clk) disable iff (rst)
    live(cursor) == live(head))
    else $error("cursor missing in non-empty list");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cll_pkg::*;

  localparam int POOL = 256;
  localparam logic [8:0] NIL = 9'd256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] command = '0;
  logic signed [31:0] value = '0;
  logic busy, done, ok, took_value, pool_full;
  logic signed [31:0] removed_value, cursor_value;
  logic [8:0] node_count;

  cursor_linked_list_engine_unit #(.POOL_DEPTH(POOL), .DATA_WIDTH(32)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .value(value), .done(done), .ok(ok), .took_value(took_value),
    .removed_value(removed_value), .cursor_value(cursor_value),
    .node_count(node_count), .pool_full(pool_full)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic        ok;
    logic        took;
    logic [31:0] removed;
    logic [31:0] cur;
    logic [8:0]  count;
    logic        full;
  } list_result_t;

  // shadow list state
  logic [31:0] sh_data [POOL];
  logic [8:0]  sh_next [POOL];
  logic [8:0]  sh_prev [POOL];
  logic [8:0]  sh_free [POOL];
  int unsigned sh_free_top, sh_fresh, sh_count;
  logic [8:0]  sh_head, sh_tail, sh_cur;

  list_result_t pending_results[$];
  int mismatches = 0;

  function automatic bit is_live(logic [8:0] i);
    return i < NIL;
  endfunction

  function automatic bit alloc_node(output logic [8:0] slot);
    slot = NIL;
    if (sh_free_top > 0) begin
      sh_free_top--;
      slot = sh_free[sh_free_top];
      return 1'b1;
    end
    if (sh_fresh < POOL) begin
      slot = sh_fresh[8:0];
      sh_fresh++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit step_cur(bit fwd);
    logic [8:0] t;
    if (!is_live(sh_head)) return 1'b0;
    if (!is_live(sh_cur)) sh_cur = sh_head;
    t = fwd ? sh_next[sh_cur] : sh_prev[sh_cur];
    if (!is_live(t)) return 1'b0;
    sh_cur = t;
    return 1'b1;
  endfunction

  function automatic bit insert_at(bit after, logic [31:0] v, inout bit full);
    logic [8:0] n, c, t;
    if (!alloc_node(n)) begin
      full = 1'b1;
      return 1'b0;
    end
    sh_data[n] = v;
    if (!is_live(sh_head)) begin
      sh_next[n] = NIL;
      sh_prev[n] = NIL;
      sh_head = n; sh_tail = n; sh_cur = n;
      sh_count = 1;
      return 1'b1;
    end
    if (!is_live(sh_cur)) sh_cur = sh_head;
    c = sh_cur;
    if (after) begin
      t = sh_next[c];
      sh_next[n] = t; sh_prev[n] = c; sh_next[c] = n;
      if (is_live(t)) sh_prev[t] = n; else sh_tail = n;
    end else begin
      t = sh_prev[c];
      sh_prev[n] = t; sh_next[n] = c; sh_prev[c] = n;
      if (is_live(t)) sh_next[t] = n; else sh_head = n;
    end
    sh_cur = n;
    sh_count++;
    return 1'b1;
  endfunction

  function automatic void free_node(logic [8:0] n);
    if (sh_free_top < POOL) begin
      sh_free[sh_free_top] = n;
      sh_free_top++;
    end
  endfunction

  function automatic bit unlink_end(bit at_head, inout logic [31:0] v, inout bit took);
    logic [8:0] n, t;
    if (!is_live(sh_head) || !is_live(sh_tail)) return 1'b0;
    n = at_head ? sh_head : sh_tail;
    t = at_head ? sh_next[n] : sh_prev[n];
    v = sh_data[n];
    took = 1'b1;
    if (is_live(t)) begin
      if (at_head) sh_prev[t] = NIL; else sh_next[t] = NIL;
    end
    free_node(n);
    sh_cur = t;
    if (at_head) sh_head = t; else sh_tail = t;
    if (sh_count > 0) sh_count--;
    if (!is_live(t)) begin
      sh_head = NIL; sh_tail = NIL; sh_cur = NIL;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit unlink_cur(inout logic [31:0] v, inout bit took);
    logic [8:0] c, nx, pv;
    if (!is_live(sh_head) || !is_live(sh_cur)) return 1'b0;
    c = sh_cur;
    if (c == sh_head) return unlink_end(1'b1, v, took);
    if (c == sh_tail) return unlink_end(1'b0, v, took);
    nx = sh_next[c]; pv = sh_prev[c];
    v = sh_data[c];
    took = 1'b1;
    if (is_live(pv)) sh_next[pv] = nx;
    if (is_live(nx)) sh_prev[nx] = pv;
    free_node(c);
    sh_cur = nx;
    if (sh_count > 0) sh_count--;
    return 1'b1;
  endfunction

  function automatic list_result_t apply_command(logic [3:0] cmd, logic [31:0] v);
    list_result_t r;
    bit okf, took, full;
    logic [31:0] rem;
    okf = 1'b0; took = 1'b0; full = 1'b0; rem = '0;
    case (cmd)
      CMD_MOVE_NEXT:  okf = step_cur(1'b1);
      CMD_MOVE_PREV:  okf = step_cur(1'b0);
      CMD_MOVE_FIRST: if (is_live(sh_head)) begin sh_cur = sh_head; okf = 1'b1; end
      CMD_MOVE_LAST:  if (is_live(sh_tail)) begin sh_cur = sh_tail; okf = 1'b1; end
      CMD_ADD_NEXT:   okf = insert_at(1'b1, v, full);
      CMD_ADD_PREV:   okf = insert_at(1'b0, v, full);
      CMD_ADD_FIRST: if (is_live(sh_head)) begin
        sh_cur = sh_head;
        okf = insert_at(1'b0, v, full);
      end
      CMD_ADD_LAST: if (is_live(sh_tail)) begin
        sh_cur = sh_tail;
        okf = insert_at(1'b1, v, full);
      end
      CMD_DEL_CUR: okf = unlink_cur(rem, took);
      CMD_DEL_NEXT:
        if (is_live(sh_head) && is_live(sh_cur) && step_cur(1'b1)) okf = unlink_cur(rem, took);
      CMD_DEL_PREV:
        if (is_live(sh_head) && is_live(sh_cur) && step_cur(1'b0)) okf = unlink_cur(rem, took);
      CMD_DEL_FIRST: okf = unlink_end(1'b1, rem, took);
      CMD_DEL_LAST:  okf = unlink_end(1'b0, rem, took);
      default: ;
    endcase
    r.ok = okf;
    r.took = took;
    r.removed = took ? rem : '0;
    r.cur = is_live(sh_cur) ? sh_data[sh_cur] : '0;
    r.count = sh_count[8:0];
    r.full = full;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // one command transaction: random gap, then hold start until accepted;
  // with no gap start stays high into the next transaction
  task automatic send_command(logic [3:0] cmd, logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    value <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(cmd, v));
  endtask

  always @(posedge clk) begin
    list_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        e = pending_results.pop_front();
        if (ok !== e.ok) report_mismatch("ok", 32'(ok), 32'(e.ok));
        if (took_value !== e.took)
          report_mismatch("took_value", 32'(took_value), 32'(e.took));
        if (removed_value !== e.removed)
          report_mismatch("removed_value", removed_value, e.removed);
        if (cursor_value !== e.cur) report_mismatch("cursor_value", cursor_value, e.cur);
        if (node_count !== e.count)
          report_mismatch("node_count", 32'(node_count), 32'(e.count));
        if (pool_full !== e.full)
          report_mismatch("pool_full", 32'(pool_full), 32'(e.full));
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // empty list corner cases and every command code
  task automatic test_empty_and_codes();
    int c;
    for (c = 0; c < 16; c++) send_command(c[3:0], rand_word());
    send_command(CMD_DEL_CUR, 0);
    send_command(CMD_ADD_PREV, 32'h8000_0000);
    send_command(CMD_ADD_NEXT, 32'h7FFF_FFFF);
    send_command(CMD_ADD_FIRST, 32'hFFFF_FFFF);
    send_command(CMD_DEL_NEXT, 0);
    send_command(CMD_DEL_PREV, 0);
    send_command(CMD_DEL_LAST, 0);
    send_command(CMD_DEL_FIRST, 0);
  endtask

  // fill the pool, overflow it, then drain it
  task automatic test_full_pool();
    int i;
    while (sh_count < POOL) send_command(4'($urandom_range(4, 7)), $urandom);
    send_command(CMD_ADD_FIRST, 32'h1234);
    send_command(CMD_ADD_NEXT, 32'h5678);
    send_command(CMD_ADD_LAST, 32'h9ABC);
    for (i = 0; i < 300 && sh_count > 0; i++) send_command(4'($urandom_range(8, 12)), 0);
    send_command(CMD_DEL_CUR, 0);
  endtask

  // random commands, biased so the list grows and shrinks through its range
  task automatic test_random(int n);
    int i, bias;
    logic [3:0] cmd;
    bias = 60;
    for (i = 0; i < n; i++) begin
      if (i % 200 == 0) bias = $urandom_range(30, 75);
      if ($urandom_range(0, 99) < 15) cmd = 4'($urandom_range(0, 15));
      else if ($urandom_range(0, 99) < bias) cmd = 4'($urandom_range(4, 7));
      else if ($urandom_range(0, 1)) cmd = 4'($urandom_range(8, 12));
      else cmd = 4'($urandom_range(0, 3));
      if (sh_count == 0 && $urandom_range(0, 1)) cmd = CMD_ADD_NEXT;
      send_command(cmd, rand_word());
    end
  endtask

  initial begin
    int waited;
    sh_free_top = 0; sh_fresh = 0; sh_count = 0;
    sh_head = NIL; sh_tail = NIL; sh_cur = NIL;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_codes();
    test_full_pool();
    test_random(900);
    test_full_pool();
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
src/cll_pkg.sv
src/cll_ram.sv
src/cursor_linked_list_engine_unit.sv
sim/tb_top.sv
